/* sv/itoa_pkg.sv */
`timescale 1ns / 1ps

package itoa_pkg;

	localparam int unsigned DIGIT_BITS = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// shift-and-add-3 correction
	localparam logic [DIGIT_BITS-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_BITS-1:0] BCD_ADJ_ADD = 4'd3;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_SHIFT,
		CV_DONE
	} cv_state_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_SKIP,
		EM_SIGN,
		EM_DIGITS
	} em_state_t;

endpackage

/* sv/itoa_dabble.sv */
`timescale 1ns / 1ps

module itoa_dabble #(
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned NDIG       = 10
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [VALUE_BITS-1:0]                       value,
	output logic                                        bcd_valid,
	input  logic                                        bcd_ready,
	output logic [itoa_pkg::DIGIT_BITS*NDIG-1:0]        bcd,
	output logic                                        neg
);

	localparam int unsigned BW = itoa_pkg::DIGIT_BITS * NDIG;
	localparam int unsigned CW = $clog2(VALUE_BITS + 1);

	itoa_pkg::cv_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BW-1:0]         bcd_q;
	logic [BW-1:0]         bcd_adj;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic                  load;
	logic                  step;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::CV_IDLE: begin
				if (in_valid) state_d = itoa_pkg::CV_SHIFT;
			end
			itoa_pkg::CV_SHIFT: begin
				if (cnt_q == CW'(1)) state_d = itoa_pkg::CV_DONE;
			end
			itoa_pkg::CV_DONE: begin
				if (bcd_ready) state_d = itoa_pkg::CV_IDLE;
			end
			default: state_d = itoa_pkg::CV_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == itoa_pkg::CV_IDLE);
		bcd_valid = (state_q == itoa_pkg::CV_DONE);
		load      = in_ready && in_valid;
		step      = (state_q == itoa_pkg::CV_SHIFT);
	end

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			logic [itoa_pkg::DIGIT_BITS-1:0] d;
			d = bcd_q[i*itoa_pkg::DIGIT_BITS +: itoa_pkg::DIGIT_BITS];
			bcd_adj[i*itoa_pkg::DIGIT_BITS +: itoa_pkg::DIGIT_BITS] =
				(d >= itoa_pkg::BCD_ADJ_MIN) ? d + itoa_pkg::BCD_ADJ_ADD : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::CV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= CW'(VALUE_BITS);
			end else if (step) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= value[VALUE_BITS-1];
			bin_q <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q <= '0;
		end else if (step) begin
			bcd_q <= {bcd_adj[BW-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign bcd = bcd_q;
	assign neg = neg_q;

endmodule

/* sv/itoa_emit.sv */
`timescale 1ns / 1ps

module itoa_emit #(
	parameter int unsigned NDIG = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 bcd_valid,
	output logic                                 bcd_ready,
	input  logic [itoa_pkg::DIGIT_BITS*NDIG-1:0] bcd,
	input  logic                                 neg,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           char_code,
	output logic                                 last
);

	localparam int unsigned BW = itoa_pkg::DIGIT_BITS * NDIG;
	localparam int unsigned LW = $clog2(NDIG + 1);

	itoa_pkg::em_state_t state_q, state_d;

	logic [BW-1:0]                     bcd_q;
	logic                              neg_q;
	logic [LW-1:0]                     left_q;
	logic [itoa_pkg::DIGIT_BITS-1:0]   top;
	logic                              top_zero;
	logic                              one_left;
	logic                              out_free;
	logic                              take;
	logic                              skip;
	logic                              emit_sign;
	logic                              emit_dig;
	logic                              out_valid_q;
	logic [7:0]                        char_q;
	logic                              last_q;

	assign top      = bcd_q[BW-1 -: itoa_pkg::DIGIT_BITS];
	assign top_zero = (top == '0);
	assign one_left = (left_q == LW'(1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::EM_IDLE: begin
				if (bcd_valid) state_d = itoa_pkg::EM_SKIP;
			end
			itoa_pkg::EM_SKIP: begin
				if (!(top_zero && !one_left)) begin
					state_d = neg_q ? itoa_pkg::EM_SIGN : itoa_pkg::EM_DIGITS;
				end
			end
			itoa_pkg::EM_SIGN: begin
				if (out_free) state_d = itoa_pkg::EM_DIGITS;
			end
			itoa_pkg::EM_DIGITS: begin
				if (out_free && one_left) state_d = itoa_pkg::EM_IDLE;
			end
			default: state_d = itoa_pkg::EM_IDLE;
		endcase
	end

	always_comb begin
		bcd_ready = (state_q == itoa_pkg::EM_IDLE);
		take      = bcd_ready && bcd_valid;
		skip      = (state_q == itoa_pkg::EM_SKIP) && top_zero && !one_left;
		emit_sign = (state_q == itoa_pkg::EM_SIGN) && out_free;
		emit_dig  = (state_q == itoa_pkg::EM_DIGITS) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoa_pkg::EM_IDLE;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				left_q <= LW'(NDIG);
			end else if (skip || emit_dig) begin
				left_q <= left_q - LW'(1);
			end
			if (emit_sign || emit_dig) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bcd_q <= bcd;
			neg_q <= neg;
		end else if (skip || emit_dig) begin
			bcd_q <= {bcd_q[BW-itoa_pkg::DIGIT_BITS-1:0], {itoa_pkg::DIGIT_BITS{1'b0}}};
		end
		if (emit_sign) begin
			char_q <= itoa_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (emit_dig) begin
			char_q <= itoa_pkg::CHAR_ZERO + {4'b0000, top};
			last_q <= one_left;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Converts one signed two's complement integer per transaction into its decimal
// text, one ASCII character per output transaction, most significant first,
// with a leading '-' for negative values and tlast on the final digit. The
// magnitude is converted by a shift-and-add-3 unit that takes one bit per
// cycle, in a load step, one shift step per bit and a handoff step; it accepts
// a new number only after the last one has been handed off. A character
// emitter then drops leading zeros one digit per cycle and sends one
// character per cycle while the output accepts them, so with a free output
// it keeps up with the converter; a stalling output side sets the pace once
// its stalls outlast the converter.
module signed_int_to_decimal_ascii #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // value
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // char_code
	output logic                                 m_axis_tlast
);

	// digits of 2^VALUE_BITS, enough for any magnitude
	localparam int unsigned NDIG = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int unsigned BW   = itoa_pkg::DIGIT_BITS * NDIG;

	logic          bcd_valid;
	logic          bcd_ready;
	logic [BW-1:0] bcd;
	logic          neg;

	itoa_dabble #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG      (NDIG)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.value    (s_axis_tdata[VALUE_BITS-1:0]),
		.bcd_valid(bcd_valid),
		.bcd_ready(bcd_ready),
		.bcd      (bcd),
		.neg      (neg)
	);

	itoa_emit #(
		.NDIG(NDIG)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.bcd_valid(bcd_valid),
		.bcd_ready(bcd_ready),
		.bcd      (bcd),
		.neg      (neg),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.char_code(m_axis_tdata),
		.last     (m_axis_tlast)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
	localparam int unsigned RANDOM_NUMBERS = 437;
	localparam int unsigned MAX_WAIT = 11;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned MAX_PRINTED = 30;
	localparam logic [31:0] TEN = 32'd10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [DATA_BITS-1:0] s_axis_tdata = '0;  // value
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;        // char_code
	logic                 m_axis_tlast;

	logic [31:0]  number_q[$];
	text_char_t   text_q[$];

	int unsigned errors = 0;
	int unsigned numbers_sent = 0;
	int unsigned negatives_sent = 0;
	int unsigned zeros_sent = 0;
	int unsigned chars_checked = 0;
	int unsigned longest_text = 0;

	// both sides run without idling while this is set
	logic no_idle = 1'b0;

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) begin
			no_idle <= ~no_idle;
		end
	end

	function automatic int unsigned draw_wait();
		if (no_idle) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("%0t: mismatch: %s", $realtime, msg);
		end
	endtask

	// decimal text of one number, sign first, most significant digit next
	function automatic void predict_text(input logic [31:0] v);
		logic        neg;
		logic [31:0] mag;
		logic [3:0]  digit[0:11];
		int          nd;
		text_char_t  c;
		neg = v[VALUE_BITS-1];
		mag = neg ? (~v + 32'd1) : v;
		nd = 0;
		do begin
			digit[nd] = 4'(mag % TEN);
			mag = mag / TEN;
			nd++;
		end while (mag != 0);
		if (neg) begin
			c.code = itoa_pkg::CHAR_MINUS;
			c.last = 1'b0;
			text_q.push_back(c);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c.code = itoa_pkg::CHAR_ZERO + 8'(digit[k]);
			c.last = (k == 0);
			text_q.push_back(c);
		end
		numbers_sent++;
		if (neg) begin
			negatives_sent++;
		end
		if (v == 0) begin
			zeros_sent++;
		end
		if (nd + int'(neg) > longest_text) begin
			longest_text = nd + int'(neg);
		end
	endfunction

	// input side
	always @(posedge clk) begin : driver
		logic                 nv;
		logic [DATA_BITS-1:0] nd;
		int unsigned          gap;
		if (!arst_n) begin
			gap = 0;
		end else begin
			nv = s_axis_tvalid;
			nd = s_axis_tdata;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_text(s_axis_tdata[31:0]);
				nv = 1'b0;
				gap = draw_wait();
			end
			if (!nv) begin
				if (gap > 0) begin
					gap--;
				end else if (number_q.size() > 0) begin
					nd = number_q.pop_front();
					nv = 1'b1;
				end
			end
			s_axis_tvalid <= nv;
			s_axis_tdata <= nd;
		end
	end

	// output side
	always @(posedge clk) begin : monitor
		logic        nr;
		int unsigned stall;
		text_char_t  want;
		if (!arst_n) begin
			stall = draw_wait();
		end else begin
			nr = m_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				if (text_q.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h last %0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = text_q.pop_front();
					if (m_axis_tdata !== want.code) begin
						report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
							m_axis_tdata, want.code));
					end
					if (m_axis_tlast !== want.last) begin
						report_mismatch($sformatf("tlast %0b, expected %0b on char 0x%02h",
							m_axis_tlast, want.last, want.code));
					end
				end
				chars_checked++;
				nr = 1'b0;
				stall = draw_wait();
			end
			if (!nr) begin
				if (stall > 0) begin
					stall--;
				end else begin
					nr = 1'b1;
				end
			end
			m_axis_tready <= nr;
		end
	end

	function automatic logic [31:0] random_number();
		int unsigned kind;
		int unsigned ndig;
		longint      lo;
		longint      hi;
		longint      mag;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			return $urandom();
		end
		if (kind < 9) begin
			ndig = $urandom_range(1, 10);
			lo = 1;
			for (int i = 1; i < ndig; i++) begin
				lo = lo * 10;
			end
			hi = lo * 10 - 1;
			if (ndig == 1) begin
				lo = 0;
			end
			if (hi > 64'd2147483647) begin
				hi = 64'd2147483647;
			end
			mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
		end else begin
			// near the ends of the range and at powers of ten
			case ($urandom_range(0, 2))
				0: mag = 64'd2147483647 - longint'($urandom_range(0, 20));
				1: mag = 64'd2147483648 - longint'($urandom_range(0, 3));
				default: begin
					mag = 1;
					for (int i = $urandom_range(0, 9); i > 0; i--) begin
						mag = mag * 10;
					end
					mag = mag + longint'($urandom_range(0, 2)) - 1;
				end
			endcase
		end
		if ($urandom_range(0, 1) == 1) begin
			mag = -mag;
		end
		return 32'(mag);
	endfunction

	initial begin : stimulus
		logic [31:0] directed[$];
		int unsigned total;
		directed = '{
			32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			-32'sd1000000000, 32'd999999999, -32'sd999999999, 32'd1234567890,
			-32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000001,
			32'd4000000000, -32'sd9, 32'd2
		};
		foreach (directed[i]) begin
			number_q.push_back(directed[i]);
		end
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			number_q.push_back(random_number());
		end
		total = number_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (numbers_sent < total || text_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d numbers (%0d negative, %0d zero), %0d characters checked",
			numbers_sent, negatives_sent, zeros_sent, chars_checked);
		$display("longest text %0d characters, %0d mismatches", longest_text, errors);
		if (errors == 0) begin
			$display("[signed_int_to_decimal_ascii] OK");
		end else begin
			$display("[signed_int_to_decimal_ascii] ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("timeout with %0d numbers and %0d characters outstanding",
			number_q.size(), text_q.size());
		$display("[signed_int_to_decimal_ascii] ERROR");
		$finish;
	end

endmodule

/* sim.f */
sv/itoa_pkg.sv
sv/itoa_dabble.sv
sv/itoa_emit.sv
sv/signed_int_to_decimal_ascii.sv
tb/sv/testbench.sv
